// ===== sv/assert_macros.svh =====
// Assertion helpers included by the tracker RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every clock edge, skipped while reset is low.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Implication checked at every clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/pct_pkg.sv =====
`timescale 1ns / 1ps
package pct_pkg;

    localparam int unsigned RSSI_W = 7;
    localparam int unsigned NODE_W = 16;
    localparam int unsigned TIME_W = 32;
    localparam int unsigned HIST_W = 3 * RSSI_W;
    localparam int unsigned MAX_RESULTS = 16;

    localparam logic [RSSI_W-1:0] RESET_THRESHOLD = 7'd62;
    localparam logic [7:0] RESET_MIN_CONTACT = 8'd11;
    localparam logic [7:0] RESET_ABSENT_LIMIT = 8'd26;
    localparam logic [7:0] RESET_SILENCE_LIMIT = 8'd30;

    // Register indexes on the configuration port.
    localparam logic [1:0] REG_THRESHOLD = 2'd0;
    localparam logic [1:0] REG_MIN_CONTACT = 2'd1;
    localparam logic [1:0] REG_ABSENT_LIMIT = 2'd2;
    localparam logic [1:0] REG_SILENCE_LIMIT = 2'd3;

    localparam logic CMD_PACKET = 1'b0;
    localparam logic CMD_SWEEP = 1'b1;
    localparam logic EVT_DETECT = 1'b0;
    localparam logic EVT_ABSENT = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_UPDATE,
        ST_EMIT,
        ST_WAIT
    } t_state;

    // One table slot as it circulates through the cell chain.
    typedef struct packed {
        logic              valid;
        logic [NODE_W-1:0] node;
        logic [TIME_W-1:0] start;
        logic [TIME_W-1:0] last_rx;
        logic [HIST_W-1:0] hist;
        logic [1:0]        count;
        logic              near;
        logic              reported;
    } t_slot;

    // Control from the sequencer to the chain.
    typedef struct packed {
        logic  shift;
        logic  load;
        t_slot load_slot;
    } t_chain_ctl;

    // Truncated average of the valid samples.
    function automatic logic [RSSI_W-1:0] avg_hist(input logic [HIST_W-1:0] h,
                                                  input logic [1:0] cnt);
        logic [RSSI_W+1:0] sum;
        logic [RSSI_W+1:0] q;
        logic [19:0]       prod;
        sum = {2'b00, h[RSSI_W-1:0]} + {2'b00, h[2*RSSI_W-1:RSSI_W]};
        q = '0;
        prod = '0;
        if (cnt <= 2'd1) begin
            q = {2'b00, h[RSSI_W-1:0]};
        end else if (cnt == 2'd2) begin
            q = sum >> 1;
        end else begin
            sum = sum + {2'b00, h[HIST_W-1:2*RSSI_W]};
            // Divide by three through a reciprocal: sum < 384.
            prod = {11'd0, sum} * 20'd683;
            q = prod[19:11];
        end
        return q[RSSI_W-1:0];
    endfunction

endpackage

// ===== sv/pct_cell.sv =====
`timescale 1ns / 1ps
module pct_cell
    import pct_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_shift,
    input  t_slot      i_prev,
    output t_slot      o_slot
);

    logic  r_valid;
    t_slot r_slot;

    // Valid bit is reset; the payload fields are written before use.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_shift) begin
            r_valid <= i_prev.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_slot <= i_prev;
        end
    end

    always_comb begin
        o_slot = r_slot;
        o_slot.valid = r_valid;
    end

endmodule

// ===== sv/pct_chain.sv =====
`timescale 1ns / 1ps
module pct_chain
    import pct_pkg::*;
#(
    parameter int unsigned ENTRIES = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_chain_ctl i_ctl,
    output t_slot      o_head
);

    t_slot w_slot [ENTRIES];

    // The chain rotates: the tail slot, or a rewritten one, re-enters cell 0.
    genvar g;
    generate
        for (g = 0; g < ENTRIES; g++) begin : g_cell
            t_slot w_in;
            if (g == 0) begin : g_first
                assign w_in = i_ctl.load ? i_ctl.load_slot : w_slot[ENTRIES-1];
            end else begin : g_rest
                assign w_in = w_slot[g-1];
            end
            pct_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (i_ctl.shift),
                .i_prev  (w_in),
                .o_slot  (w_slot[g])
            );
        end
    endgenerate

    assign o_head = w_slot[ENTRIES-1];

endmodule

// ===== sv/proximity_contact_tracker.sv =====
`timescale 1ns / 1ps
// Proximity contact tracker.
// Input words (s_axis) are packets (cmd 0) or absence sweeps (cmd 1).
// Result words (m_axis) are DETECT or ABSENT events; tlast marks the
// final event caused by one input word. Items that cause no event give none.
// The neighbor table is a ring of ENTRIES cells. A packet rotates it once to
// locate its slot and a second time to rotate back and write the updated slot
// in place; a packet that finds no room rotates it only once. A sweep rotates
// the ring once; one event is held back so that tlast can go on the final
// one, and the rotation stalls while both the held event and the output word
// wait.
// A stalled receiver can hold the ring, and no input word is taken until
// every event of the current word has been delivered.
// Reset clears all valid bits and restores register defaults.
// Registers over APB: 0 threshold, 1 min contact, 2 absent limit,
// 3 silence limit, at byte addresses 0, 4, 8, 12.
module proximity_contact_tracker
    import pct_pkg::*;
#(
    parameter int unsigned ENTRIES = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata: [15:0] node_id, [47:16] now_seconds, [54:48] rssi_magnitude
    input  logic [55:0] s_axis_tdata,
    // tuser: [0] cmd
    input  logic        s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tdata: [15:0] event_node, [47:16] event_time
    output logic [47:0] m_axis_tdata,
    // tuser: [0] event_kind
    output logic        m_axis_tuser,
    output logic        m_axis_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int unsigned IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int unsigned CW = $clog2(ENTRIES + 1);
    localparam int unsigned RW = $clog2(MAX_RESULTS + 1);

    logic [RSSI_W-1:0] r_thr;
    logic [7:0] r_minc, r_absl, r_sil;
    logic w_wr;

    // Configuration registers.
    assign pready = 1'b1;
    assign w_wr = psel & penable & pwrite;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= RESET_THRESHOLD;
            r_minc <= RESET_MIN_CONTACT;
            r_absl <= RESET_ABSENT_LIMIT;
            r_sil <= RESET_SILENCE_LIMIT;
        end else if (w_wr && paddr[1:0] == 2'b00) begin
            case (paddr[3:2])
                REG_THRESHOLD: r_thr <= pwdata[RSSI_W-1:0];
                REG_MIN_CONTACT: r_minc <= pwdata[7:0];
                REG_ABSENT_LIMIT: r_absl <= pwdata[7:0];
                REG_SILENCE_LIMIT: r_sil <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        case (paddr[3:2])
            REG_THRESHOLD: prdata = {25'd0, r_thr};
            REG_MIN_CONTACT: prdata = {24'd0, r_minc};
            REG_ABSENT_LIMIT: prdata = {24'd0, r_absl};
            REG_SILENCE_LIMIT: prdata = {24'd0, r_sil};
            default: prdata = '0;
        endcase
    end

    t_state r_state, n_state;
    logic r_cmd, n_cmd;
    logic [NODE_W-1:0] r_id, n_id;
    logic [TIME_W-1:0] r_now, n_now;
    logic [RSSI_W-1:0] r_rssi, n_rssi;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [IW-1:0] r_hit, n_hit, r_free, n_free;
    logic r_found, n_found, r_has_free, n_has_free;
    logic [RW-1:0] r_nres, n_nres;
    logic r_ovalid, n_ovalid;
    logic r_okind, n_okind, r_olast, n_olast;
    logic [NODE_W-1:0] r_onode, n_onode;
    logic [TIME_W-1:0] r_otime, n_otime;
    logic r_hvalid, n_hvalid;
    logic [NODE_W-1:0] r_hnode, n_hnode;
    logic [TIME_W-1:0] r_htime, n_htime;
    t_slot w_head;
    t_chain_ctl w_ctl;

    pct_chain #(.ENTRIES(ENTRIES)) u_chain (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .o_head  (w_head)
    );

    // Packet update of the head slot.
    t_slot w_upd;
    logic w_upd_evt, w_upd_kind;
    logic [TIME_W-1:0] w_age;
    logic [RSSI_W-1:0] w_avg;
    logic [TIME_W-1:0] w_silent;

    assign w_age = r_now - w_head.start;
    assign w_silent = r_now - w_head.last_rx;

    always_comb begin
        w_upd = w_head;
        w_upd_evt = 1'b0;
        w_upd_kind = EVT_DETECT;
        w_avg = '0;
        if (!r_found) begin
            w_upd.valid = 1'b1;
            w_upd.node = r_id;
            w_upd.start = r_now;
            w_upd.last_rx = r_now;
            w_upd.hist = {{(2*RSSI_W){1'b0}}, r_rssi};
            w_upd.count = 2'd1;
            w_upd.near = (r_rssi < r_thr);
            w_upd.reported = 1'b0;
        end else begin
            w_upd.last_rx = r_now;
            w_upd.hist = {w_head.hist[2*RSSI_W-1:0], r_rssi};
            if (w_head.count < 2'd3) begin
                w_upd.count = w_head.count + 2'd1;
            end
            w_avg = avg_hist(w_upd.hist, w_upd.count);
            if (w_avg < r_thr) begin
                if (w_head.near) begin
                    if (w_age > {24'd0, r_minc} && !w_head.reported) begin
                        w_upd.reported = 1'b1;
                        w_upd_evt = 1'b1;
                        w_upd_kind = EVT_DETECT;
                    end
                end else begin
                    w_upd.near = 1'b1;
                    w_upd.start = r_now;
                end
            end else begin
                if (!w_head.near) begin
                    if (w_age > {24'd0, r_absl} && w_head.reported) begin
                        w_upd_evt = 1'b1;
                        w_upd_kind = EVT_ABSENT;
                        w_upd.valid = 1'b0;
                    end
                end else begin
                    w_upd.start = r_now;
                    w_upd.near = 1'b0;
                end
            end
        end
    end

    logic [IW-1:0] w_pos;
    logic w_sweep_hit;
    assign w_pos = r_cnt[IW-1:0];
    assign w_sweep_hit = w_head.valid && w_head.reported &&
                         (w_silent > {24'd0, r_sil}) &&
                         (r_nres < RW'(MAX_RESULTS));

    // Sequencer: scan, rewrite, and sweep over the rotating ring.
    always_comb begin
        n_state = r_state;
        n_cmd = r_cmd;
        n_id = r_id;
        n_now = r_now;
        n_rssi = r_rssi;
        n_cnt = r_cnt;
        n_hit = r_hit;
        n_free = r_free;
        n_found = r_found;
        n_has_free = r_has_free;
        n_nres = r_nres;
        n_ovalid = r_ovalid;
        n_okind = r_okind;
        n_olast = r_olast;
        n_onode = r_onode;
        n_otime = r_otime;
        n_hvalid = r_hvalid;
        n_hnode = r_hnode;
        n_htime = r_htime;
        w_ctl = '0;
        w_ctl.load_slot = w_head;
        s_axis_tready = 1'b0;
        if (r_ovalid && m_axis_tready) begin
            n_ovalid = 1'b0;
        end
        case (r_state)
            ST_IDLE: begin
                s_axis_tready = !r_ovalid;
                if (s_axis_tvalid && !r_ovalid) begin
                    n_cmd = s_axis_tuser;
                    n_id = s_axis_tdata[15:0];
                    n_now = s_axis_tdata[47:16];
                    n_rssi = s_axis_tdata[54:48];
                    n_cnt = '0;
                    n_found = 1'b0;
                    n_has_free = 1'b0;
                    n_nres = '0;
                    n_hvalid = 1'b0;
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                // Head holds the slot that r_cnt names (positions count up).
                if (r_cmd == CMD_SWEEP) begin
                    if (w_sweep_hit) begin
                        // The held event goes out as a non-final word.
                        if (!r_hvalid || !r_ovalid || m_axis_tready) begin
                            w_ctl.shift = 1'b1;
                            w_ctl.load = 1'b1;
                            w_ctl.load_slot.valid = 1'b0;
                            if (r_hvalid) begin
                                n_ovalid = 1'b1;
                                n_okind = EVT_ABSENT;
                                n_onode = r_hnode;
                                n_otime = r_htime;
                                n_olast = 1'b0;
                            end
                            n_hvalid = 1'b1;
                            n_hnode = w_head.node;
                            n_htime = w_head.start;
                            n_nres = r_nres + 1'b1;
                            n_cnt = r_cnt + 1'b1;
                        end
                    end else begin
                        w_ctl.shift = 1'b1;
                        n_cnt = r_cnt + 1'b1;
                    end
                    if (n_cnt == CW'(ENTRIES)) begin
                        n_state = ST_WAIT;
                    end
                end else begin
                    w_ctl.shift = 1'b1;
                    n_cnt = r_cnt + 1'b1;
                    if (!r_found && w_head.valid && w_head.node == r_id) begin
                        n_found = 1'b1;
                        n_hit = w_pos;
                    end
                    if (!w_head.valid && !r_has_free) begin
                        n_has_free = 1'b1;
                        n_free = w_pos;
                    end
                    if (r_cnt == CW'(ENTRIES - 1)) begin
                        n_cnt = '0;
                        n_state = ST_UPDATE;
                        if (!n_found) begin
                            n_hit = n_free;
                            if (!n_has_free) begin
                                n_state = ST_IDLE;
                            end
                        end
                    end
                end
            end
            ST_UPDATE: begin
                // Rotate until the target reaches the head, then rewrite it.
                if (w_pos == r_hit && (!r_ovalid || m_axis_tready)) begin
                    w_ctl.shift = 1'b1;
                    w_ctl.load = 1'b1;
                    w_ctl.load_slot = w_upd;
                    n_cnt = r_cnt + 1'b1;
                    if (w_upd_evt) begin
                        n_ovalid = 1'b1;
                        n_okind = w_upd_kind;
                        n_onode = w_head.node;
                        n_otime = w_head.start;
                        n_olast = 1'b1;
                    end
                    n_state = (n_cnt == CW'(ENTRIES)) ? ST_IDLE : ST_EMIT;
                end else if (w_pos != r_hit) begin
                    w_ctl.shift = 1'b1;
                    n_cnt = r_cnt + 1'b1;
                end
            end
            ST_EMIT: begin
                // Finish the rotation so slot order is restored.
                w_ctl.shift = 1'b1;
                n_cnt = r_cnt + 1'b1;
                if (n_cnt == CW'(ENTRIES)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_WAIT: begin
                // Send the held sweep event as the final word.
                if (!r_hvalid) begin
                    n_state = ST_IDLE;
                end else if (!r_ovalid || m_axis_tready) begin
                    n_ovalid = 1'b1;
                    n_okind = EVT_ABSENT;
                    n_onode = r_hnode;
                    n_otime = r_htime;
                    n_olast = 1'b1;
                    n_hvalid = 1'b0;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ovalid <= 1'b0;
            r_nres <= '0;
            r_hvalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ovalid <= n_ovalid;
            r_nres <= n_nres;
            r_hvalid <= n_hvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd;
        r_id <= n_id;
        r_now <= n_now;
        r_rssi <= n_rssi;
        r_cnt <= n_cnt;
        r_hit <= n_hit;
        r_free <= n_free;
        r_found <= n_found;
        r_has_free <= n_has_free;
        r_okind <= n_okind;
        r_olast <= n_olast;
        r_onode <= n_onode;
        r_otime <= n_otime;
        r_hnode <= n_hnode;
        r_htime <= n_htime;
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata = {r_otime, r_onode};
    assign m_axis_tuser = r_okind;
    assign m_axis_tlast = r_olast;

`include "assert_macros.svh"

    `ASSERT_CLK(a_no_take_busy, i_clk, i_rst_n,
        s_axis_tready |-> (r_state == ST_IDLE && !r_ovalid),
        "input taken while busy")
    `ASSERT_CLK(a_res_cap, i_clk, i_rst_n,
        r_nres <= RW'(MAX_RESULTS), "too many sweep results")
    `ASSERT_CLK(a_out_hold, i_clk, i_rst_n,
        (r_ovalid && !m_axis_tready) |=> (r_ovalid && $stable({m_axis_tlast, m_axis_tuser, m_axis_tdata})),
        "result changed while stalled")

endmodule
